// ===== hw/rtl/pflau_pkg.sv =====
// ----------------------------------------------------------------------------
// PFLAU target count parser package
// Shared types, character constants and the prefix table of the parser.
// ----------------------------------------------------------------------------
package pflau_pkg;

    localparam int unsigned PREFIX_LEN  = 7;
    localparam int unsigned PM_WIDTH    = $clog2(PREFIX_LEN);
    localparam int unsigned COUNT_WIDTH = 16;
    localparam int unsigned PROD_WIDTH  = 20;

    localparam logic [PM_WIDTH-1:0]   PREFIX_LAST = PM_WIDTH'(PREFIX_LEN - 1);
    localparam logic [PROD_WIDTH-1:0] COUNT_MAX   = PROD_WIDTH'(65535);

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_P      = 8'h50;
    localparam logic [7:0] CHAR_F      = 8'h46;
    localparam logic [7:0] CHAR_L      = 8'h4C;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_U      = 8'h55;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;

    typedef enum logic [3:0] {
        PH_SEARCH = 4'b0001,
        PH_FIELD  = 4'b0010,
        PH_OK     = 4'b0100,
        PH_FAIL   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic                   found;
        logic [COUNT_WIDTH-1:0] traffic_count;
    } out_beat_t;

    typedef struct packed {
        phase_t                 phase;
        logic [PM_WIDTH-1:0]    prefix_matched;
        logic                   digit_seen;
        logic [COUNT_WIDTH-1:0] accumulator;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:          PH_SEARCH,
        prefix_matched: '0,
        digit_seen:     1'b0,
        accumulator:    '0
    };

    // Expected character at each position of the "$PFLAU," prefix.
    function automatic logic [7:0] prefix_char(input logic [PM_WIDTH-1:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = CHAR_DOLLAR;
            3'd1: ch = CHAR_P;
            3'd2: ch = CHAR_F;
            3'd3: ch = CHAR_L;
            3'd4: ch = CHAR_A;
            3'd5: ch = CHAR_U;
            3'd6: ch = CHAR_COMMA;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== hw/rtl/pflau_step.sv =====
// ----------------------------------------------------------------------------
// PFLAU parser step logic
// Combinational update of the parse state for one byte, and the result that
// the buffer would give if this byte were its last.
// ----------------------------------------------------------------------------
module pflau_step (
    input  pflau_pkg::parse_state_t state_cur,
    input  logic [7:0]              byte_value,
    output pflau_pkg::parse_state_t state_next,
    output pflau_pkg::out_beat_t    result
);
    import pflau_pkg::*;

    logic                  is_digit;
    logic                  is_delim;
    logic [PROD_WIDTH-1:0] acc_ext;
    logic [PROD_WIDTH-1:0] acc_prod;
    logic                  ok;

    assign is_digit = (byte_value >= CHAR_ZERO) && (byte_value <= CHAR_NINE);
    assign is_delim = (byte_value == CHAR_COMMA) || (byte_value == CHAR_CR) ||
                      (byte_value == CHAR_LF);

    // Times ten as two shifts; the low nibble of an ASCII digit is its value.
    assign acc_ext  = PROD_WIDTH'(state_cur.accumulator);
    assign acc_prod = (acc_ext << 3) + (acc_ext << 1) + PROD_WIDTH'(byte_value[3:0]);

    always_comb begin
        state_next = state_cur;
        case (state_cur.phase)
            PH_SEARCH: begin
                if (byte_value == prefix_char(state_cur.prefix_matched)) begin
                    if (state_cur.prefix_matched == PREFIX_LAST) begin
                        state_next.phase          = PH_FIELD;
                        state_next.prefix_matched = '0;
                        state_next.digit_seen     = 1'b0;
                        state_next.accumulator    = '0;
                    end else begin
                        state_next.prefix_matched = state_cur.prefix_matched +
                                                    PM_WIDTH'(1);
                    end
                end else if (byte_value == CHAR_DOLLAR) begin
                    state_next.prefix_matched = PM_WIDTH'(1);
                end else begin
                    state_next.prefix_matched = '0;
                end
            end
            PH_FIELD: begin
                if (is_digit) begin
                    state_next.accumulator = acc_prod[COUNT_WIDTH-1:0];
                    state_next.digit_seen  = 1'b1;
                    if (acc_prod > COUNT_MAX) begin
                        state_next.phase = PH_FAIL;
                    end
                end else if (state_cur.digit_seen && is_delim) begin
                    state_next.phase = PH_OK;
                end else begin
                    state_next.phase = PH_FAIL;
                end
            end
            default: begin
                // Outcome already known: hold until the end of the buffer.
            end
        endcase
    end

    assign ok = (state_next.phase == PH_OK) ||
                ((state_next.phase == PH_FIELD) && state_next.digit_seen);

    assign result.found         = ok;
    assign result.traffic_count = ok ? state_next.accumulator : '0;

endmodule

// ===== hw/rtl/pflau_target_count_parser_top.sv =====
// ----------------------------------------------------------------------------
// PFLAU target count parser
// Finds the first "$PFLAU," sentence in a byte buffer and returns its count.
// ----------------------------------------------------------------------------
// The block takes one byte per beat and sustains one beat per clock cycle
// unless a last byte is stalled. Each byte is held in an input register while
// the parse state is updated; a buffer's result is then presented through a
// result register that lets the next buffer's bytes flow in while the result
// waits to be taken. Only a buffer's last byte can stall: it waits while an
// earlier result is still untaken. Only the last byte of a buffer produces a
// result beat; the parser then restarts for the next buffer.
module pflau_target_count_parser_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pflau_pkg::in_beat_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pflau_pkg::out_beat_t  m_data
);
    import pflau_pkg::*;

    logic         in_valid_reg;
    in_beat_t     in_beat_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    out_beat_t    result_next;
    logic         m_valid_reg;
    out_beat_t    m_beat_reg;
    logic         advance;
    logic         emit;

    pflau_step u_step (
        .state_cur  (state_reg),
        .byte_value (in_beat_reg.byte_value),
        .state_next (state_next),
        .result     (result_next)
    );

    // A byte that produces no result never waits for the result register.
    assign advance = in_valid_reg &&
                     (!in_beat_reg.last_byte || !m_valid_reg || m_ready);
    assign emit    = advance && in_beat_reg.last_byte;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= STATE_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg <= in_beat_reg.last_byte ? STATE_RESET : state_next;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_beat_reg <= s_data;
        end
        if (emit) begin
            m_beat_reg <= result_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_beat_reg;

`ifndef NO_ASSERTIONS
    a_fail_zero_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_beat_reg.found) |-> (m_beat_reg.traffic_count == '0))
        else $error("result without a count carries a non-zero count");

    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (state_reg.phase == PH_SEARCH && state_reg.prefix_matched == '0))
        else $error("parser did not restart after the last byte of a buffer");

    a_prefix_only_searching: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.prefix_matched != '0) |-> (state_reg.phase == PH_SEARCH))
        else $error("partial prefix match held outside the search phase");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !emit)
        else $error("result register overwritten while still waiting");
`endif

endmodule

// ===== sim/pflau_count_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PFLAU target count checker
// Watches both channels of the parser. It predicts the result of every byte
// buffer from the accepted input beats and compares each result beat, field
// by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pflau_count_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  pflau_pkg::in_beat_t  s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  pflau_pkg::out_beat_t m_data,
    output int                   fail_count,
    output int                   pending,
    output int                   results_seen,
    output int                   found_seen
);
    import pflau_pkg::*;

    localparam logic [8*PREFIX_LEN-1:0] SENTENCE_HEAD = {
        CHAR_DOLLAR, CHAR_P, CHAR_F, CHAR_L, CHAR_A, CHAR_U, CHAR_COMMA
    };

    phase_t                scan_phase;
    logic [PM_WIDTH-1:0]   head_hits;
    logic                  have_digit;
    logic [PROD_WIDTH-1:0] count_acc;

    out_beat_t count_expected[$];

    function automatic void clear_parse();
        scan_phase = PH_SEARCH;
        head_hits  = '0;
        have_digit = 1'b0;
        count_acc  = '0;
    endfunction

    function automatic void advance_parse(input logic [7:0] b);
        logic       is_digit;
        logic [7:0] want;
        is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        case (scan_phase)
            PH_SEARCH: begin
                want = SENTENCE_HEAD[8*PREFIX_LEN-1 - 8*head_hits -: 8];
                if (b == want) begin
                    if (head_hits == PREFIX_LAST) begin
                        scan_phase = PH_FIELD;
                        head_hits  = '0;
                        have_digit = 1'b0;
                        count_acc  = '0;
                    end else begin
                        head_hits = head_hits + PM_WIDTH'(1);
                    end
                end else begin
                    // A stray '$' may itself open the next sentence.
                    head_hits = (b == CHAR_DOLLAR) ? PM_WIDTH'(1) : '0;
                end
            end
            PH_FIELD: begin
                if (is_digit) begin
                    count_acc  = count_acc * PROD_WIDTH'(10) + PROD_WIDTH'(b - CHAR_ZERO);
                    have_digit = 1'b1;
                    if (count_acc > COUNT_MAX) begin
                        scan_phase = PH_FAIL;
                    end
                end else if (have_digit &&
                             (b == CHAR_COMMA || b == CHAR_CR || b == CHAR_LF)) begin
                    scan_phase = PH_OK;
                end else begin
                    scan_phase = PH_FAIL;
                end
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge aclk) begin : monitor
        out_beat_t want_beat;
        if (!aresetn) begin
            clear_parse();
            count_expected.delete();
            fail_count   = 0;
            results_seen = 0;
            found_seen   = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_data.found) begin
                    found_seen++;
                end
                if (count_expected.size() == 0) begin
                    $display("%0t: result beat with nothing expected: found=%0b count=%0d",
                             $time, m_data.found, m_data.traffic_count);
                    fail_count++;
                end else begin
                    want_beat = count_expected.pop_front();
                    if (m_data.found !== want_beat.found) begin
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, want_beat.found, m_data.found);
                        fail_count++;
                    end
                    if (m_data.traffic_count !== want_beat.traffic_count) begin
                        $display("%0t: traffic_count mismatch: expected %0d, actual %0d",
                                 $time, want_beat.traffic_count, m_data.traffic_count);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                advance_parse(s_data.byte_value);
                if (s_data.last_byte) begin
                    want_beat.found = (scan_phase == PH_OK) ||
                                      (scan_phase == PH_FIELD && have_digit);
                    want_beat.traffic_count = want_beat.found ? count_acc[COUNT_WIDTH-1:0]
                                                              : '0;
                    count_expected.push_back(want_beat);
                    clear_parse();
                end
            end
        end
        pending = count_expected.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PFLAU target count parser testbench
// Sends directed and random byte buffers, some well-formed sentences and some
// broken or pure noise, under changing back-pressure on both channels. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import pflau_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 350;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    int checker_fails;
    int results_pending;
    int results_seen;
    int found_seen;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_len;
    int hold_seq;
    int bytes_sent;
    int frames_sent;

    logic [7:0] frame_bytes[$];
    string      sentence_head = "$PFLAU,";

    pflau_target_count_parser_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    pflau_count_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .fail_count   (checker_fails),
        .pending      (results_pending),
        .results_seen (results_seen),
        .found_seen   (found_seen)
    );

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("pflau_target_count_parser_top test failed");
        $finish;
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    // The hold-off is counted down here; the stimulus only asks for one.
    initial begin : result_sink
        int hold_left;
        int hold_seen;
        m_ready   = 1'b0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        frame_bytes.push_back(b);
    endtask

    task automatic push_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            frame_bytes.push_back(t[i]);
        end
    endtask

    // Called just after a rising edge; returns just after the accepting edge.
    task automatic send_beat(input logic [7:0] b, input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_data.byte_value <= b;
        s_data.last_byte  <= last;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
        end
        frame_bytes.delete();
        frames_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (results_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic make_random_frame();
        int kind;
        int n;
        int v;
        kind = $urandom_range(99);
        if (kind < 70) begin
            n = $urandom_range(0, 3);
            repeat (n) begin
                case ($urandom_range(3))
                    0: push_byte(8'($urandom_range(255)));
                    1: push_byte(CHAR_DOLLAR);
                    2: push_text("$PF");
                    default: push_text("PFLAU,");
                endcase
            end
            push_text(sentence_head);
            if ($urandom_range(9) == 0) begin
                push_text("00");
            end
            case ($urandom_range(9))
                0: v = 65535;
                1: v = $urandom_range(65536, 999999);
                2, 3: v = $urandom_range(65535);
                default: v = $urandom_range(999);
            endcase
            push_text($sformatf("%0d", v));
            case ($urandom_range(5))
                0: push_byte(CHAR_COMMA);
                1: push_byte(CHAR_CR);
                2: push_byte(CHAR_LF);
                3: begin
                end
                4: push_byte(8'($urandom_range(255)));
                default: push_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
            endcase
            n = $urandom_range(0, 4);
            repeat (n) push_byte(8'($urandom_range(255)));
        end else if (kind < 85) begin
            n = $urandom_range(1, 6);
            push_text(sentence_head.substr(0, n - 1));
            push_byte(8'($urandom_range(255)));
            if ($urandom_range(1) == 1) begin
                push_text(sentence_head);
                push_byte(8'($urandom_range(255)));
                if ($urandom_range(1) == 1) begin
                    push_byte(8'($urandom_range(255)));
                end
            end
        end else begin
            n = $urandom_range(1, 12);
            repeat (n) push_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic run_random(input int send_pct, input int recv_pct);
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target        = bytes_sent + PHASE_BYTES;
        while (bytes_sent < target) begin
            make_random_frame();
            send_frame();
        end
    endtask

    initial begin : stimulus
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        send_idle_pct = 15;
        recv_idle_pct = 68;
        hold_len      = 0;
        hold_seq      = 0;
        bytes_sent    = 0;
        frames_sent   = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed buffers: limits of the count, each way a field can end,
        // restarts of the prefix search and bytes after a decided outcome.
        push_text("$PFLAU,0");
        send_frame();
        push_text("$PFLAU,65535,");
        send_frame();
        push_text("$PFLAU,65536");
        push_byte(CHAR_CR);
        send_frame();
        push_text("$PFLAU,999999");
        send_frame();
        push_text("$$PFLAU,12");
        push_byte(CHAR_LF);
        send_frame();
        push_text("$PFL$PFLAU,7,x");
        send_frame();
        push_text("$PFXAU,5");
        send_frame();
        push_text("$PFLAU,,3");
        send_frame();
        push_text(sentence_head);
        push_byte(CHAR_CR);
        send_frame();
        push_text(sentence_head);
        push_byte(CHAR_LF);
        send_frame();
        push_text(sentence_head);
        send_frame();
        push_text("$PFLAU,1A");
        send_frame();
        push_text("$PFLAU,42,$PFLAU,9");
        push_byte(8'hFF);
        send_frame();
        push_byte(8'h00);
        send_frame();
        push_byte(8'hFF);
        send_frame();
        push_byte(8'hFF);
        push_byte(8'h00);
        push_text("$PFLAU,9");
        send_frame();
        push_text("$PFLAU,3");
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        send_frame();
        drain_results();

        run_random(15, 68);
        drain_results();
        run_random(68, 15);
        drain_results();

        // No idling, but a long hold-off at the start so that the result
        // register fills and the input side has to stall.
        hold_len = 300;
        hold_seq++;
        run_random(0, 0);
        drain_results();

        $display("Sent %0d bytes in %0d buffers under three back-pressure mixes.",
                 bytes_sent, frames_sent);
        $display("Checked %0d results, %0d of them with a count found.",
                 results_seen, found_seen);
        if (checker_fails == 0 && results_pending == 0) begin
            $display("pflau_target_count_parser_top test passed");
        end else begin
            $display("pflau_target_count_parser_top test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/pflau_pkg.sv
hw/rtl/pflau_step.sv
hw/rtl/pflau_target_count_parser_top.sv
sim/pflau_count_checker.sv
sim/tb_top.sv
